>>> rtl/atrg_pkg.sv
// ============================================================================
// atrg_pkg - shared types and codes for the association table replay guard
// Request and status codes, table row layout, controller/datapath bundles.
// ============================================================================
`default_nettype none

package atrg_pkg;

	// drops reported by one sweep at most
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		REQ_OFFER = 2'd0,
		REQ_PROT  = 2'd1,
		REQ_SWEEP = 2'd2,
		REQ_CLEAR = 2'd3
	} atrg_req_t;

	typedef enum logic [3:0] {
		RS_ANSWERED  = 4'd0,
		RS_STALE     = 4'd1,
		RS_FULL      = 4'd2,
		RS_XCHG_FAIL = 4'd3,
		RS_DELIVER   = 4'd4,
		RS_NO_ENTRY  = 4'd5,
		RS_BAD_TAG   = 4'd6,
		RS_REPLAY    = 4'd7,
		RS_EXPIRED   = 4'd8,
		RS_NONE_EXP  = 4'd9,
		RS_CLEARED   = 4'd10
	} atrg_status_t;

	// one table row as held in the RAM
	typedef struct packed {
		logic [31:0] address;
		logic [15:0] port;
		logic [31:0] offer_word;
		logic [31:0] high_word;
		logic [63:0] last_tick;
	} atrg_row_t;

	// controller -> datapath
	typedef struct packed {
		logic start;   // capture request, reset scan
		logic rd;      // read row at scan index
		logic look;    // track match / free slot
		logic drop;    // sweep drops the current row
		logic step;    // advance scan index
		logic finish;  // final word and write-back
	} atrg_cmd_t;

	// datapath -> controller
	typedef struct packed {
		atrg_req_t req_type;
		logic      last_idx;
		logic      expired;
		logic      pend_v;
		logic      out_free;
		logic      cnt_last;
	} atrg_sts_t;

endpackage

`default_nettype wire

>>> rtl/atrg_if.sv
// ============================================================================
// atrg_if - request and response channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ============================================================================
`default_nettype none

interface atrg_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] peer_address;
	logic [15:0] peer_port;
	logic [31:0] seq_word_a;
	logic [31:0] offer_word;
	logic        check_passed;
	logic [63:0] now_tick;

	modport source (output valid, req_type, peer_address, peer_port, seq_word_a,
		offer_word, check_passed, now_tick, input ready);
	modport sink (input valid, req_type, peer_address, peer_port, seq_word_a,
		offer_word, check_passed, now_tick, output ready);
endinterface

interface atrg_rsp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [3:0]  slot_index;
	logic [31:0] dropped_address;
	logic [15:0] dropped_port;
	logic        last_result;

	modport source (output valid, status, slot_index, dropped_address, dropped_port,
		last_result, input ready);
	modport sink (input valid, status, slot_index, dropped_address, dropped_port,
		last_result, output ready);
endinterface

`default_nettype wire

>>> rtl/atrg_ram.sv
// ============================================================================
// atrg_ram - generic single write / single read RAM
// One write port, one read port with registered read data.
// ============================================================================
`default_nettype none

module atrg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/atrg_ctrl.sv
// ============================================================================
// atrg_ctrl - request sequencer
// Walks the table one row per read/check pair, then issues the final word.
// ============================================================================
`default_nettype none

module atrg_ctrl import atrg_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_type,
	output logic            in_ready,
	input  wire atrg_sts_t  sts,
	output atrg_cmd_t       cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_READ   = 2'd1;
	localparam logic [1:0] ST_CHECK  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = (atrg_req_t'(in_type) == REQ_CLEAR) ? ST_FINISH : ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.req_type == REQ_SWEEP) begin
					if (sts.expired) begin
						// a pending drop must leave through a free output register
						if (!sts.pend_v || sts.out_free) begin
							cmd.drop = 1'b1;
							if (sts.cnt_last || sts.last_idx) begin
								state_d = ST_FINISH;
							end else begin
								cmd.step = 1'b1;
								state_d  = ST_READ;
							end
						end
					end else if (sts.last_idx) begin
						state_d = ST_FINISH;
					end else begin
						cmd.step = 1'b1;
						state_d  = ST_READ;
					end
				end else begin
					cmd.look = 1'b1;
					if (sts.last_idx) begin
						state_d = ST_FINISH;
					end else begin
						cmd.step = 1'b1;
						state_d  = ST_READ;
					end
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/atrg_dp.sv
// ============================================================================
// atrg_dp - table datapath
// Row RAM, live/seen bits, scan tracking, sweep pending word, output register.
// ============================================================================
`default_nettype none

module atrg_dp import atrg_pkg::*; #(
	parameter int TABLE_ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire atrg_cmd_t   cmd,
	output atrg_sts_t        sts,
	input  wire logic [1:0]  in_type,
	input  wire logic [31:0] in_address,
	input  wire logic [15:0] in_port,
	input  wire logic [31:0] in_word_a,
	input  wire logic [31:0] in_word_b,
	input  wire logic        in_ok,
	input  wire logic [63:0] in_now,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       out_status,
	output logic [3:0]       out_slot,
	output logic [31:0]      out_address,
	output logic [15:0]      out_port,
	output logic             out_last
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// captured request
	atrg_req_t   type_q;
	logic [31:0] addr_q, worda_q, wordb_q;
	logic [15:0] port_q;
	logic        ok_q;
	logic [63:0] now_q;

	logic [31:0]              timeout_q;
	logic [TABLE_ENTRIES-1:0] live_q, seen_q;
	logic [IDX_W-1:0]         idx_q;
	logic                     found_q, free_found_q;
	logic [IDX_W-1:0]         match_q, free_q;
	atrg_row_t                match_row_q;
	logic [CNT_W-1:0]         cnt_q;

	// pending sweep drop (held until we know whether it is the last)
	logic             pend_v_q;
	logic [IDX_W-1:0] pend_slot_q;
	logic [31:0]      pend_addr_q;
	logic [15:0]      pend_port_q;

	logic out_v_q;

	atrg_row_t rd_row, wb_row;
	logic      key_eq, expired;
	logic [63:0] age;

	// final word and write-back
	atrg_status_t     res_status;
	logic [IDX_W-1:0] res_slot, wb_slot;
	logic [31:0]      res_addr;
	logic [15:0]      res_port;
	logic             wb_en, wb_seen, clear_all;
	logic [IDX_W-1:0] tgt;

	atrg_ram #(
		.WIDTH ($bits(atrg_row_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_rows (
		.clk   (clk),
		.we    (cmd.finish & wb_en),
		.waddr (wb_slot),
		.wdata (wb_row),
		.re    (cmd.rd),
		.raddr (idx_q),
		.rdata (rd_row)
	);

	assign key_eq  = live_q[idx_q] && (rd_row.address == addr_q) && (rd_row.port == port_q);
	assign age     = now_q - rd_row.last_tick;
	assign expired = live_q[idx_q] && (age > {32'd0, timeout_q});

	always_comb begin
		sts.req_type = type_q;
		sts.last_idx = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
		sts.expired  = expired;
		sts.pend_v   = pend_v_q;
		sts.out_free = !out_v_q || out_ready;
		sts.cnt_last = (CNT_W'(cnt_q + CNT_W'(1)) == CNT_W'(MAX_RESULTS));
	end

	always_comb begin
		res_status = RS_CLEARED;
		res_slot   = '0;
		res_addr   = '0;
		res_port   = '0;
		wb_en      = 1'b0;
		wb_seen    = 1'b0;
		wb_slot    = match_q;
		wb_row     = match_row_q;
		clear_all  = 1'b0;
		tgt        = found_q ? match_q : free_q;
		unique case (type_q)
			REQ_OFFER: begin
				if (found_q && (wordb_q <= match_row_q.offer_word)) begin
					res_status = RS_STALE;
					res_slot   = match_q;
				end else if (!found_q && !free_found_q) begin
					res_status = RS_FULL;
				end else if (!ok_q) begin
					res_status = RS_XCHG_FAIL;
					res_slot   = tgt;
				end else begin
					res_status        = RS_ANSWERED;
					res_slot          = tgt;
					wb_en             = 1'b1;
					wb_slot           = tgt;
					wb_row.address    = addr_q;
					wb_row.port       = port_q;
					wb_row.offer_word = wordb_q;
					wb_row.high_word  = '0;
					wb_row.last_tick  = now_q;
				end
			end
			REQ_PROT: begin
				if (!found_q) begin
					res_status = RS_NO_ENTRY;
				end else if (!ok_q) begin
					res_status = RS_BAD_TAG;
					res_slot   = match_q;
				end else if (!seen_q[match_q] || (worda_q > match_row_q.high_word)) begin
					res_status       = RS_DELIVER;
					res_slot         = match_q;
					wb_en            = 1'b1;
					wb_seen          = 1'b1;
					wb_row.high_word = worda_q;
					wb_row.last_tick = now_q;
				end else begin
					res_status = RS_REPLAY;
					res_slot   = match_q;
				end
			end
			REQ_SWEEP: begin
				if (pend_v_q) begin
					res_status = RS_EXPIRED;
					res_slot   = pend_slot_q;
					res_addr   = pend_addr_q;
					res_port   = pend_port_q;
				end else begin
					res_status = RS_NONE_EXP;
				end
			end
			REQ_CLEAR: begin
				clear_all = 1'b1;
			end
			default: res_status = RS_CLEARED;
		endcase
	end

	// request, matched row and pending drop capture
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			addr_q  <= in_address;
			port_q  <= in_port;
			worda_q <= in_word_a;
			wordb_q <= in_word_b;
			ok_q    <= in_ok;
			now_q   <= in_now;
		end
		if (cmd.look && key_eq && !found_q) begin
			match_row_q <= rd_row;
		end
		if (cmd.drop) begin
			pend_slot_q <= idx_q;
			pend_addr_q <= rd_row.address;
			pend_port_q <= rd_row.port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q       <= REQ_OFFER;
			timeout_q    <= 32'd10000;
			live_q       <= '0;
			seen_q       <= '0;
			idx_q        <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			match_q      <= '0;
			free_q       <= '0;
			cnt_q        <= '0;
			pend_v_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_data;
			end
			if (cmd.start) begin
				type_q       <= atrg_req_t'(in_type);
				idx_q        <= '0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				cnt_q        <= '0;
				pend_v_q     <= 1'b0;
			end
			if (cmd.step) begin
				idx_q <= IDX_W'(idx_q + IDX_W'(1));
			end
			if (cmd.look) begin
				if (key_eq && !found_q) begin
					found_q <= 1'b1;
					match_q <= idx_q;
				end
				if (!live_q[idx_q] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_q       <= idx_q;
				end
			end
			if (cmd.drop) begin
				live_q[idx_q] <= 1'b0;
				seen_q[idx_q] <= 1'b0;
				pend_v_q      <= 1'b1;
				cnt_q         <= CNT_W'(cnt_q + CNT_W'(1));
			end
			if (cmd.finish) begin
				if (clear_all) begin
					live_q <= '0;
					seen_q <= '0;
				end else if (wb_en) begin
					live_q[wb_slot] <= 1'b1;
					seen_q[wb_slot] <= wb_seen;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_status  <= res_status;
			out_slot    <= 4'(res_slot);
			out_address <= res_addr;
			out_port    <= res_port;
			out_last    <= 1'b1;
		end else if (cmd.drop && pend_v_q) begin
			out_status  <= RS_EXPIRED;
			out_slot    <= 4'(pend_slot_q);
			out_address <= pend_addr_q;
			out_port    <= pend_port_q;
			out_last    <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.finish || (cmd.drop && pend_v_q)) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign out_valid = out_v_q;

endmodule

`default_nettype wire

>>> rtl/association_table_replay_guard.sv
// ============================================================================
// association_table_replay_guard - peer association table with replay guard
// Offers, protected datagrams, idle sweeps and clears against a small table.
// ============================================================================
// Offer, protected datagram and sweep scan the rows (READ then CHECK per row), then
//   FINISH issues the final word; a sweep also ends at MAX_RESULTS drops. Clear goes
//   straight from accept to FINISH. A new request is taken only after the final word,
//   the row scan being one RAM read and one check per row through a single read port.
// Sweeps with several drops stall while the output register is held.
// Reset: table empty at once (live bits cleared), idle_timeout = 10000.
`default_nettype none

module association_table_replay_guard import atrg_pkg::*; #(
	parameter int TABLE_ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	atrg_req_if.sink         req,
	atrg_rsp_if.source       rsp,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_data
);

	atrg_cmd_t cmd;
	atrg_sts_t sts;

	// controller: accepts a word only when idle, then sequences the scan
	atrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_type  (req.req_type),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: row RAM, live/seen flags, match tracking, output register
	atrg_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_type     (req.req_type),
		.in_address  (req.peer_address),
		.in_port     (req.peer_port),
		.in_word_a   (req.seq_word_a),
		.in_word_b   (req.offer_word),
		.in_ok       (req.check_passed),
		.in_now      (req.now_tick),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_status  (rsp.status),
		.out_slot    (rsp.slot_index),
		.out_address (rsp.dropped_address),
		.out_port    (rsp.dropped_port),
		.out_last    (rsp.last_result)
	);

	// the output register is only loaded when it is free
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish || (cmd.drop && sts.pend_v)) |-> sts.out_free)
		else $error("output word overwritten");

	// the final word returns the block to idle
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> req.ready)
		else $error("not idle after final word");

	// a new request is never taken mid-scan
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !(cmd.rd || cmd.look || cmd.drop || cmd.finish))
		else $error("request taken while busy");

	// an intermediate sweep drop word never carries last_result
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.drop && sts.pend_v) |=> !rsp.last_result)
		else $error("intermediate drop marked last");

endmodule

`default_nettype wire
